/* src/fbpa_pkg.sv */
// Package for the fixed block pool allocator: sizes, codes and shared types.
// Used by every module in src; depends on nothing.
package fbpa_pkg;

	// Stack depth and the widths; the count widths follow from the depth.
	localparam int DEPTH  = 256;
	localparam int ADDR_W = 32;
	localparam int CNT_W  = $clog2(DEPTH) + 1;
	localparam int BB_W   = 16;
	localparam int CFG_W  = 32;
	localparam int IDX_W  = 2;
	localparam int PROD_W = CNT_W + BB_W;

	// Register reset values.
	localparam logic [ADDR_W-1:0] BASE_RST  = '0;
	localparam logic [BB_W-1:0]   BBYTES_RST = BB_W'(64);
	localparam logic [CNT_W-1:0]  BCOUNT_RST = CNT_W'(8);

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_BASE_ADDRESS = 2'd0,
		REG_BLOCK_BYTES  = 2'd1,
		REG_BLOCK_COUNT  = 2'd2
	} reg_idx_t;

	// Requested operation.
	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	// Result status.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// Shift control broadcast to every stack cell.
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

endpackage

/* src/fixed_block_pool_allocator_unit.sv */
// Fixed block pool allocator: a free-address stack built as a row of shift cells.
// A taken request's result is registered with done, which is high for one cycle;
// busy is high for the cycle after a request is taken, and no new request is taken
// while it is high. The receiver cannot stall. arst_n clears counts, registers and
// control at once; stack cells are not reset and need no clearing pass.
module fixed_block_pool_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port.
	input  logic                          cfg_we,
	input  logic [fbpa_pkg::IDX_W-1:0]    cfg_index,
	input  logic [fbpa_pkg::CFG_W-1:0]    cfg_data,
	// Request side.
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [fbpa_pkg::ADDR_W-1:0]   free_address,
	// Result side.
	output logic                          done,
	output logic [fbpa_pkg::ADDR_W-1:0]   block_address,
	output fbpa_pkg::status_t             status,
	output logic [fbpa_pkg::CNT_W-1:0]    in_use,
	output logic [fbpa_pkg::CNT_W-1:0]    peak_in_use
);
	import fbpa_pkg::*;

	// Configuration registers.
	logic [ADDR_W-1:0] base_q;
	logic [BB_W-1:0]   bbytes_q;
	logic [CNT_W-1:0]  bcount_q;

	// Pool counters.
	logic [CNT_W-1:0]  used_q;
	logic [CNT_W-1:0]  peak_q;

	// First stage: the captured request and the lazy-fill offset product.
	logic              busy_q;
	logic              func_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [PROD_W-1:0] prod_s1;

	// Result registers.
	logic              done_q;
	logic [ADDR_W-1:0] result_addr_q;
	status_t           status_q;

	logic              accept;
	logic [CNT_W-1:0]  cap;
	logic [CNT_W-1:0]  slot;
	logic              restart;

	// Second stage decisions.
	cell_ctrl_t        ctrl;
	logic              inc_used;
	logic              dec_used;
	logic              raise_peak;
	logic [ADDR_W-1:0] next_addr;
	status_t           next_status;

	logic [ADDR_W-1:0] cell_data [DEPTH];

	assign accept  = start && !busy_q;
	assign restart = cfg_we && (cfg_index == REG_BLOCK_COUNT);

	// The capacity is the block count held to the range one to DEPTH.
	always_comb begin
		if (bcount_q == '0) begin
			cap = CNT_W'(1);
		end else if (bcount_q > CNT_W'(DEPTH)) begin
			cap = CNT_W'(DEPTH);
		end else begin
			cap = bcount_q;
		end
	end

	// Slot that the next pop reaches; only meaningful while a block is free.
	assign slot = cap - used_q - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= BASE_RST;
			bbytes_q <= BBYTES_RST;
			bcount_q <= BCOUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_ADDRESS: base_q   <= cfg_data[ADDR_W-1:0];
				REG_BLOCK_BYTES:  bbytes_q <= cfg_data[BB_W-1:0];
				REG_BLOCK_COUNT:  bcount_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// The first stage takes the request and forms slot times block size, so the
	// second stage has only an add left for a lazily filled address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			addr_s1 <= free_address;
			prod_s1 <= PROD_W'(slot) * PROD_W'(bbytes_q);
		end
	end

	// The cells hold only the addresses that were pushed back. Every free slot
	// below them has never been reached, and the peak count marks that edge: a
	// pop made while the in-use count equals its peak reaches a fresh slot and
	// takes base plus slot times block size instead of the top cell.
	always_comb begin
		ctrl        = '0;
		inc_used    = 1'b0;
		dec_used    = 1'b0;
		raise_peak  = 1'b0;
		next_addr   = '0;
		next_status = ST_OK;
		if (busy_q) begin
			case (func_t'(func_s1))
				FUNC_ALLOC: begin
					if (used_q == cap) begin
						next_status = ST_EMPTY;
					end else if (used_q == peak_q) begin
						next_addr  = base_q + ADDR_W'(prod_s1);
						inc_used   = 1'b1;
						raise_peak = 1'b1;
					end else begin
						next_addr = cell_data[0];
						ctrl.pop  = 1'b1;
						inc_used  = 1'b1;
					end
				end
				FUNC_FREE: begin
					if (used_q == '0) begin
						next_status = ST_OVERFLOW;
					end else begin
						ctrl.push = 1'b1;
						dec_used  = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Counters; a write of the block count restarts the pool.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			peak_q <= '0;
		end else if (restart) begin
			used_q <= '0;
			peak_q <= '0;
		end else begin
			if (inc_used) begin
				used_q <= used_q + CNT_W'(1);
			end else if (dec_used) begin
				used_q <= used_q - CNT_W'(1);
			end
			if (raise_peak) begin
				peak_q <= used_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			result_addr_q <= next_addr;
			status_q      <= next_status;
		end
	end

	// The row of stack cells; cell zero is the top of the stack.
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [ADDR_W-1:0] up_data;
		logic [ADDR_W-1:0] down_data;

		if (k == 0) begin : g_top
			assign up_data = addr_s1;
		end else begin : g_mid
			assign up_data = cell_data[k-1];
		end

		if (k == DEPTH - 1) begin : g_bottom
			assign down_data = '0;
		end else begin : g_upper
			assign down_data = cell_data[k+1];
		end

		fbpa_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.from_up   (up_data),
			.from_down (down_data),
			.data      (cell_data[k])
		);
	end

	assign busy          = busy_q;
	assign done          = done_q;
	assign block_address = result_addr_q;
	assign status        = status_q;
	assign in_use        = used_q;
	assign peak_in_use   = peak_q;

endmodule

/* src/fbpa_cell.sv */
// One cell of the shift stack: holds one free block address.
// Depends on fbpa_pkg.
module fbpa_cell (
	input  logic                       clk,
	input  fbpa_pkg::cell_ctrl_t       ctrl,
	input  logic [fbpa_pkg::ADDR_W-1:0] from_up,
	input  logic [fbpa_pkg::ADDR_W-1:0] from_down,
	output logic [fbpa_pkg::ADDR_W-1:0] data
);
	import fbpa_pkg::*;

	logic [ADDR_W-1:0] data_q;

	// A push moves every entry one cell deeper, a pop one cell toward the top.
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			data_q <= from_up;
		end else if (ctrl.pop) begin
			data_q <= from_down;
		end
	end

	assign data = data_q;

endmodule

/* src/fbpa_checker.sv */
// Port-level checks for the fixed block pool allocator, bound to its top level.
// Depends on fbpa_pkg and fixed_block_pool_allocator_unit.
module fbpa_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          done,
	input  logic [fbpa_pkg::ADDR_W-1:0]   block_address,
	input  fbpa_pkg::status_t             status,
	input  logic [fbpa_pkg::CNT_W-1:0]    in_use,
	input  logic [fbpa_pkg::CNT_W-1:0]    peak_in_use
);
	import fbpa_pkg::*;

	// Every taken request is followed by its result on done.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("request taken without a result two cycles later");

	// Busy is high only in the cycle right after a request was taken.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> $past(start && !busy))
		else $error("busy without a request taken");

	// A failed allocation or a failed free gives a zero address.
	a_zero_address: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_EMPTY || status == ST_OVERFLOW)) |-> (block_address == '0))
		else $error("nonzero address on a failed request");

	// The in-use count is never above its peak when a result is given.
	a_peak_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (in_use <= peak_in_use))
		else $error("in-use count above its peak");

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker (.*);

/* verif/tb_fixed_block_pool_allocator_unit.sv */
// Self-checking testbench for fixed_block_pool_allocator_unit: directed and random
// allocate/free requests, checked against an in-bench model of the free-address stack.
// Depends on fbpa_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module tb_fixed_block_pool_allocator_unit;
	import fbpa_pkg::*;

	// Give up long after the slowest correct run would have finished.
	localparam int unsigned CYCLE_LIMIT = 400000;

	// One pending request. A request marked drain is not launched until every
	// reply for the requests ahead of it has come back.
	typedef struct {
		func_t             op;
		logic [ADDR_W-1:0] addr;
		bit                drain;
	} pool_req_t;

	// One expected reply, field for field as the block reports it.
	typedef struct {
		logic [ADDR_W-1:0] block_address;
		status_t           status;
		logic [CNT_W-1:0]  in_use;
		logic [CNT_W-1:0]  peak_in_use;
	} pool_reply_t;

	logic               clk;
	logic               arst_n       = 1'b0;
	logic               cfg_we       = 1'b0;
	logic [IDX_W-1:0]   cfg_index    = '0;
	logic [CFG_W-1:0]   cfg_data     = '0;
	logic               start        = 1'b0;
	logic               busy;
	logic               func         = 1'b0;
	logic [ADDR_W-1:0]  free_address = '0;
	logic               done;
	logic [ADDR_W-1:0]  block_address;
	status_t            status;
	logic [CNT_W-1:0]   in_use;
	logic [CNT_W-1:0]   peak_in_use;

	pool_req_t   pending_reqs[$];
	pool_reply_t expected_replies[$];
	int          in_flight       = 0;
	int          sender_idle_pct = 0;
	int          mismatch_count  = 0;
	int unsigned cycle_count     = 0;

	// Model of the pool: register copies, the free-address stack, the counts and
	// the lowest stack slot reached so far (slots below it are filled on demand).
	logic [ADDR_W-1:0] pool_base;
	logic [BB_W-1:0]   pool_block_bytes;
	logic [CNT_W-1:0]  pool_block_count;
	logic [ADDR_W-1:0] free_stack [DEPTH];
	logic [CNT_W-1:0]  used_blocks;
	logic [CNT_W-1:0]  peak_blocks;
	int                fill_mark;

	fixed_block_pool_allocator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.free_address  (free_address),
		.done          (done),
		.block_address (block_address),
		.status        (status),
		.in_use        (in_use),
		.peak_in_use   (peak_in_use)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The capacity is the block count held to 1..DEPTH; zero behaves as one.
	function automatic int pool_capacity();
		if (pool_block_count == 0)
			return 1;
		if (int'(pool_block_count) > DEPTH)
			return DEPTH;
		return int'(pool_block_count);
	endfunction

	// Any write of the block count empties the pool and clears the peak.
	function automatic void restart_pool();
		used_blocks = '0;
		peak_blocks = '0;
		fill_mark   = pool_capacity();
	endfunction

	// Applies one request to the model and returns the reply it must produce.
	// The top of the stack sits at slot (capacity - used - 1). A pop below the
	// fill mark hands out base + slot * block size, exactly as if the stack had
	// been loaded in full at start-up; a pop at or above it returns whatever
	// address was last pushed there.
	function automatic pool_reply_t predict_pool_reply(func_t op, logic [ADDR_W-1:0] addr);
		pool_reply_t r;
		int          cap;
		int          slot;
		cap = pool_capacity();
		r.block_address = '0;
		r.status        = ST_OK;
		if (op == FUNC_ALLOC) begin
			if (int'(used_blocks) >= cap) begin
				r.status = ST_EMPTY;
			end else begin
				slot = cap - int'(used_blocks) - 1;
				if (slot < fill_mark) begin
					r.block_address = pool_base + ADDR_W'(slot) * ADDR_W'(pool_block_bytes);
					fill_mark = slot;
				end else begin
					r.block_address = free_stack[slot];
				end
				used_blocks++;
				if (used_blocks > peak_blocks)
					peak_blocks = used_blocks;
			end
		end else begin
			// Freeing pushes any address unchecked, foreign ones included.
			if (used_blocks == 0) begin
				r.status = ST_OVERFLOW;
			end else begin
				slot = cap - int'(used_blocks);
				free_stack[slot] = addr;
				used_blocks--;
			end
		end
		r.in_use      = used_blocks;
		r.peak_in_use = peak_blocks;
		return r;
	endfunction

	task automatic flag_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 200)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Register writes go through here so the model follows the block. Callers
	// only use this while no request is queued or outstanding.
	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_BASE_ADDRESS: pool_base = val[ADDR_W-1:0];
			REG_BLOCK_BYTES: pool_block_bytes = val[BB_W-1:0];
			REG_BLOCK_COUNT: begin
				pool_block_count = val[CNT_W-1:0];
				restart_pool();
			end
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_req(func_t op, logic [ADDR_W-1:0] addr, bit drain = 1'b0);
		pool_req_t r;
		r.op    = op;
		r.addr  = addr;
		r.drain = drain;
		pending_reqs.push_back(r);
	endtask

	// Returns once the request queue is empty, start is low and every reply is
	// back. Checked on the falling edge so the driver's rising-edge updates have
	// all settled.
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || start || in_flight != 0);
		repeat (3) @(posedge clk);
	endtask

	// Random traffic shaped like real use: runs of allocations followed by runs
	// of frees, long enough to hit both a full and an empty pool, with some
	// scattered short runs of one to three requests mixed in. Free addresses are
	// a mix of plausible block addresses, all-zero / all-one, and arbitrary values.
	task automatic queue_random_phase(int n);
		int                cap;
		int                run;
		int                left;
		func_t             op;
		func_t             burst_op;
		logic [ADDR_W-1:0] a;
		cap      = pool_capacity();
		left     = n;
		burst_op = FUNC_ALLOC;
		while (left > 0) begin
			if ($urandom_range(99) < 85) begin
				run      = $urandom_range(cap + 2, 1);
				op       = burst_op;
				burst_op = (burst_op == FUNC_ALLOC) ? FUNC_FREE : FUNC_ALLOC;
			end else begin
				run = $urandom_range(3, 1);
				op  = func_t'($urandom_range(1));
			end
			for (int k = 0; k < run && left > 0; k++) begin
				case ($urandom_range(3))
					0: a = pool_base + ADDR_W'($urandom_range(cap - 1)) * ADDR_W'(pool_block_bytes);
					1: a = $urandom_range(1) ? '1 : '0;
					default: a = $urandom();
				endcase
				queue_req(op, a, $urandom_range(99) < 2);
				left--;
			end
		end
	endtask

	// Driver. Holds start with the current request until the block takes it,
	// predicts the reply at the edge that takes it, and keeps its own count of
	// replies still owed so that a drain request can wait for zero.
	always @(posedge clk) begin
		bit        took;
		int        owed;
		pool_req_t r;
		if (!arst_n) begin
			in_flight <= 0;
		end else begin
			took = start && !busy;
			owed = in_flight + (took ? 1 : 0) - (done ? 1 : 0);
			if (took)
				expected_replies.push_back(predict_pool_reply(func_t'(func), free_address));
			in_flight <= owed;
			if (took || !start) begin
				if (pending_reqs.size() != 0 && !(pending_reqs[0].drain && owed != 0) &&
				    $urandom_range(99) >= sender_idle_pct) begin
					r = pending_reqs.pop_front();
					start        <= 1'b1;
					func         <= r.op;
					free_address <= r.addr;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor. Every done pulse is one reply; it must match the oldest
	// prediction in every field.
	always @(posedge clk) begin
		pool_reply_t want;
		if (arst_n && done) begin
			if (expected_replies.size() == 0) begin
				flag_mismatch($sformatf("reply with none expected: addr %h status %0d",
				                        block_address, status));
			end else begin
				want = expected_replies.pop_front();
				if (block_address !== want.block_address)
					flag_mismatch($sformatf("block_address %h, want %h",
					                        block_address, want.block_address));
				if (status !== want.status)
					flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
				if (in_use !== want.in_use)
					flag_mismatch($sformatf("in_use %0d, want %0d", in_use, want.in_use));
				if (peak_in_use !== want.peak_in_use)
					flag_mismatch($sformatf("peak_in_use %0d, want %0d",
					                        peak_in_use, want.peak_in_use));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_fixed_block_pool_allocator_unit: errors");
			$finish;
		end
	end

	initial begin
		int idle_plan [3];
		int cap;
		idle_plan = '{0, 50, 7};

		// Model starts from the register reset values.
		pool_base        = BASE_RST;
		pool_block_bytes = BBYTES_RST;
		pool_block_count = BCOUNT_RST;
		restart_pool();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration: base 0, 64-byte blocks, 8 blocks. Free on an
		// empty pool overflows, eight allocations walk the whole pool, a ninth
		// finds it empty, and two frees are handed back by two allocations last-in first-out.
		@(negedge clk);
		queue_req(FUNC_FREE, '0);
		for (int k = 0; k < 9; k++)
			queue_req(FUNC_ALLOC, '1);
		queue_req(FUNC_FREE, '1, 1'b1);
		queue_req(FUNC_FREE, '0);
		queue_req(FUNC_ALLOC, '0);
		queue_req(FUNC_ALLOC, '0);
		wait_quiet();

		// Base near the top of the address space so block addresses wrap.
		write_reg(REG_BASE_ADDRESS, 32'hFFFF_FFF0);
		write_reg(REG_BLOCK_BYTES, 32'h0000_0020);
		write_reg(REG_BLOCK_COUNT, 32'd3);
		@(negedge clk);
		for (int k = 0; k < 3; k++)
			queue_req(FUNC_ALLOC, 32'h0000_0000);
		queue_req(FUNC_FREE, 32'h5A5A_A5A5);
		wait_quiet();

		// Zero block size and a block count of zero, which acts as one block.
		write_reg(REG_BLOCK_BYTES, 32'd0);
		write_reg(REG_BLOCK_COUNT, 32'd0);
		@(negedge clk);
		queue_req(FUNC_ALLOC, '0);
		queue_req(FUNC_ALLOC, '0);
		queue_req(FUNC_FREE, 32'h1234_5678);
		queue_req(FUNC_FREE, 32'h8765_4321);
		queue_req(FUNC_ALLOC, '0);
		wait_quiet();

		// Random phases. Each rewrites base and block size; the block count is
		// left alone every third phase so earlier stack contents carry over.
		for (int ph = 0; ph < 8; ph++) begin
			sender_idle_pct = idle_plan[ph % 3];
			case (ph)
				0: begin
					write_reg(REG_BASE_ADDRESS, $urandom());
					write_reg(REG_BLOCK_BYTES, 32'd1);
					write_reg(REG_BLOCK_COUNT, 32'd256);
				end
				1: begin
					write_reg(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
					write_reg(REG_BLOCK_BYTES, 32'hFFFF_FFFF);
					write_reg(REG_BLOCK_COUNT, 32'd5);
				end
				3: begin
					// Upper bits of the write data are dropped: count is one.
					write_reg(REG_BASE_ADDRESS, $urandom());
					write_reg(REG_BLOCK_BYTES, 32'd0);
					write_reg(REG_BLOCK_COUNT, 32'hFFFF_FE01);
				end
				4: begin
					// A count above the depth is held to the depth.
					write_reg(REG_BASE_ADDRESS, $urandom());
					write_reg(REG_BLOCK_BYTES, $urandom_range(65535, 1));
					write_reg(REG_BLOCK_COUNT, 32'h0000_01FF);
				end
				default: begin
					write_reg(REG_BASE_ADDRESS, (ph == 2) ? 32'd0 : $urandom());
					write_reg(REG_BLOCK_BYTES, $urandom_range(65535, 1));
					if (ph % 3 != 2)
						write_reg(REG_BLOCK_COUNT, $urandom_range(40, 2));
				end
			endcase
			cap = pool_capacity();
			@(negedge clk);
			queue_random_phase((cap > 64) ? 230 : 110);
			wait_quiet();
		end

		repeat (8) @(posedge clk);
		if (expected_replies.size() != 0)
			flag_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));
		if (mismatch_count == 0) begin
			$display("tb_fixed_block_pool_allocator_unit: clean");
		end else begin
			$display("tb_fixed_block_pool_allocator_unit: errors");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/fbpa_pkg.sv
src/fbpa_cell.sv
src/fixed_block_pool_allocator_unit.sv
src/fbpa_checker.sv
verif/tb_fixed_block_pool_allocator_unit.sv
